// ===== sv/lpg_pkg.sv =====
package lpg_pkg;

    localparam int COLOR_BITS = 24;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_front_state;

    // Per-line stepping controls handed from the front part to the back part.
    typedef struct packed {
        logic y_long;
        logic step_neg;
    } t_line_ctl;

endpackage

// ===== sv/lpg_in_if.sv =====
interface lpg_in_if #(
    parameter int COORD_BITS = 6
);
    logic                           valid;
    logic                           ready;
    logic [COORD_BITS-1:0]          x_start;
    logic [COORD_BITS-1:0]          y_start;
    logic [COORD_BITS-1:0]          x_end;
    logic [COORD_BITS-1:0]          y_end;
    logic [lpg_pkg::COLOR_BITS-1:0] pixel_color;

    modport source (
        output valid, x_start, y_start, x_end, y_end, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, x_start, y_start, x_end, y_end, pixel_color,
        output ready
    );
endinterface

// ===== sv/lpg_out_if.sv =====
interface lpg_out_if #(
    parameter int COORD_BITS = 6
);
    logic                           valid;
    logic                           ready;
    logic [COORD_BITS-1:0]          point_x;
    logic [COORD_BITS-1:0]          point_y;
    logic [lpg_pkg::COLOR_BITS-1:0] point_color;
    logic                           last_point;

    modport source (
        output valid, point_x, point_y, point_color, last_point,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_color, last_point,
        output ready
    );
endinterface

// ===== sv/lpg_front.sv =====
module lpg_front #(
    parameter int COORD_BITS    = 6,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lpg_in_if.sink                               i_line,
    output logic                                 o_push_valid,
    input  logic                                 i_push_ready,
    output lpg_pkg::t_line_ctl                   o_ctl,
    output logic [COORD_BITS-1:0]                o_major,
    output logic [COORD_BITS-1:0]                o_minor,
    output logic [COORD_BITS-1:0]                o_len,
    output logic [COORD_BITS+FRACTION_BITS-1:0]  o_inc,
    output logic [lpg_pkg::COLOR_BITS-1:0]       o_color
);

    localparam int ACC_BITS  = COORD_BITS + FRACTION_BITS;
    localparam int DIV_STEPS = ACC_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

    lpg_pkg::t_front_state r_state, n_state;

    logic [COORD_BITS-1:0]          r_major, r_minor, r_al;
    logic                           r_y_long, r_short_neg, r_long_neg;
    logic [lpg_pkg::COLOR_BITS-1:0] r_color;
    logic [ACC_BITS-1:0]            r_num;
    logic [COORD_BITS-1:0]          r_rem;
    logic [CNT_BITS-1:0]            r_cnt;

    logic [COORD_BITS:0]   w_dx, w_dy;
    logic [COORD_BITS-1:0] w_ax, w_ay;
    logic                  w_y_long;
    logic                  w_accept;
    logic [COORD_BITS:0]   w_trial;
    logic                  w_fits;
    logic [COORD_BITS:0]   w_diff;

    assign i_line.ready = (r_state == lpg_pkg::FR_IDLE);
    assign w_accept     = i_line.valid && i_line.ready;

    // Signed deltas one bit wider than a coordinate; magnitudes fit a coordinate.
    assign w_dx     = {1'b0, i_line.x_end} - {1'b0, i_line.x_start};
    assign w_dy     = {1'b0, i_line.y_end} - {1'b0, i_line.y_start};
    assign w_ax     = w_dx[COORD_BITS] ? COORD_BITS'(-w_dx) : w_dx[COORD_BITS-1:0];
    assign w_ay     = w_dy[COORD_BITS] ? COORD_BITS'(-w_dy) : w_dy[COORD_BITS-1:0];
    assign w_y_long = w_ay > w_ax;

    // One restoring division step: the numerator register fills with quotient bits.
    assign w_trial = {r_rem, r_num[ACC_BITS-1]};
    assign w_fits  = w_trial >= {1'b0, r_al};
    assign w_diff  = w_trial - {1'b0, r_al};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpg_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpg_pkg::FR_IDLE: begin
                if (w_accept) begin
                    n_state = lpg_pkg::FR_DIV;
                end
            end
            lpg_pkg::FR_DIV: begin
                if (r_al == '0 || r_cnt == CNT_BITS'(1)) begin
                    n_state = lpg_pkg::FR_PUSH;
                end
            end
            lpg_pkg::FR_PUSH: begin
                if (i_push_ready) begin
                    n_state = lpg_pkg::FR_IDLE;
                end
            end
            default: n_state = lpg_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_y_long    <= w_y_long;
            r_major     <= w_y_long ? i_line.y_start : i_line.x_start;
            r_minor     <= w_y_long ? i_line.x_start : i_line.y_start;
            r_al        <= w_y_long ? w_ay : w_ax;
            r_long_neg  <= w_y_long ? w_dy[COORD_BITS] : w_dx[COORD_BITS];
            r_short_neg <= w_y_long ? w_dx[COORD_BITS] : w_dy[COORD_BITS];
            r_num       <= {(w_y_long ? w_ax : w_ay), {FRACTION_BITS{1'b0}}};
            r_rem       <= '0;
            r_cnt       <= CNT_BITS'(DIV_STEPS);
            r_color     <= i_line.pixel_color;
        end else if (r_state == lpg_pkg::FR_DIV && r_al != '0) begin
            r_num <= {r_num[ACC_BITS-2:0], w_fits};
            r_rem <= w_fits ? w_diff[COORD_BITS-1:0] : w_trial[COORD_BITS-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // A zero long delta leaves the numerator at zero, which is the slope wanted.
    assign o_push_valid   = (r_state == lpg_pkg::FR_PUSH);
    assign o_ctl.y_long   = r_y_long;
    assign o_ctl.step_neg = r_long_neg;
    assign o_major        = r_major;
    assign o_minor        = r_minor;
    assign o_len          = r_al;
    assign o_inc          = r_short_neg ? ACC_BITS'(-r_num) : r_num;
    assign o_color        = r_color;

endmodule

// ===== sv/lpg_queue.sv =====
module lpg_queue #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== sv/lpg_back.sv =====
module lpg_back #(
    parameter int COORD_BITS    = 6,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_pop_valid,
    output logic                                 o_pop_ready,
    input  lpg_pkg::t_line_ctl                   i_ctl,
    input  logic [COORD_BITS-1:0]                i_major,
    input  logic [COORD_BITS-1:0]                i_minor,
    input  logic [COORD_BITS-1:0]                i_len,
    input  logic [COORD_BITS+FRACTION_BITS-1:0]  i_inc,
    input  logic [lpg_pkg::COLOR_BITS-1:0]       i_color,
    lpg_out_if.source                            o_point
);

    localparam int ACC_BITS = COORD_BITS + FRACTION_BITS;

    logic                           r_busy;
    lpg_pkg::t_line_ctl             r_ctl;
    logic [COORD_BITS-1:0]          r_major, r_left;
    logic [ACC_BITS-1:0]            r_acc, r_inc;
    logic [lpg_pkg::COLOR_BITS-1:0] r_color;

    logic                           r_out_valid, r_out_last;
    logic [COORD_BITS-1:0]          r_out_x, r_out_y;
    logic [lpg_pkg::COLOR_BITS-1:0] r_out_color;

    logic                  w_out_free, w_emit, w_last, w_pop;
    logic [COORD_BITS-1:0] w_minor;

    assign w_out_free  = !r_out_valid || o_point.ready;
    assign w_emit      = r_busy && w_out_free;
    assign w_last      = (r_left == '0);
    assign o_pop_ready = !r_busy || (w_emit && w_last);
    assign w_pop       = i_pop_valid && o_pop_ready;
    // The accumulator never leaves the raster, so its integer part is the floor.
    assign w_minor     = r_acc[ACC_BITS-1:FRACTION_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_point.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_pop) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_x     <= r_ctl.y_long ? w_minor : r_major;
            r_out_y     <= r_ctl.y_long ? r_major : w_minor;
            r_out_color <= r_color;
            r_out_last  <= w_last;
        end
        if (w_pop) begin
            r_ctl   <= i_ctl;
            r_major <= i_major;
            r_left  <= i_len;
            r_inc   <= i_inc;
            r_color <= i_color;
            // Start half a unit above the minor coordinate.
            r_acc   <= {i_minor, 1'b1, {(FRACTION_BITS-1){1'b0}}};
        end else if (w_emit) begin
            r_major <= r_ctl.step_neg ? r_major - 1'b1 : r_major + 1'b1;
            r_left  <= r_left - 1'b1;
            r_acc   <= r_acc + r_inc;
        end
    end

    assign o_point.valid       = r_out_valid;
    assign o_point.point_x     = r_out_x;
    assign o_point.point_y     = r_out_y;
    assign o_point.point_color = r_out_color;
    assign o_point.last_point  = r_out_last;

endmodule

// ===== sv/line_point_generator.sv =====
// Line point generator.
// Input channel i_line carries one line per item: two endpoints and a colour.
// Output channel o_point carries one item per point of that line, from the first
// endpoint to the second inclusive, with last_point set on the final one.
// The front part takes a line, works out the longer axis and runs a restoring
// division for the slope, one quotient bit per cycle; the division is skipped
// when the line is a single point. A two-entry queue holds prepared lines, so
// the next division overlaps the current line.
// The back part emits one point per cycle while the receiver takes them.
// A stall on o_point holds the presented point and freezes stepping; the queue
// then fills and i_line.ready falls. Synchronous reset drops all lines in flight
// and leaves both channels idle; no clearing pass is needed.
module line_point_generator #(
    parameter int COORD_BITS    = 6,
    parameter int FRACTION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpg_in_if.sink     i_line,
    lpg_out_if.source  o_point
);

    localparam int ACC_BITS = COORD_BITS + FRACTION_BITS;
    localparam int DESC_W   = $bits(lpg_pkg::t_line_ctl) + 3 * COORD_BITS + ACC_BITS
                              + lpg_pkg::COLOR_BITS;

    logic                           f_valid, f_ready;
    lpg_pkg::t_line_ctl             f_ctl;
    logic [COORD_BITS-1:0]          f_major, f_minor, f_len;
    logic [ACC_BITS-1:0]            f_inc;
    logic [lpg_pkg::COLOR_BITS-1:0] f_color;

    logic                           b_valid, b_ready;
    lpg_pkg::t_line_ctl             b_ctl;
    logic [COORD_BITS-1:0]          b_major, b_minor, b_len;
    logic [ACC_BITS-1:0]            b_inc;
    logic [lpg_pkg::COLOR_BITS-1:0] b_color;

    logic [DESC_W-1:0] w_push_data, w_pop_data;

    lpg_front #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line       (i_line),
        .o_push_valid (f_valid),
        .i_push_ready (f_ready),
        .o_ctl        (f_ctl),
        .o_major      (f_major),
        .o_minor      (f_minor),
        .o_len        (f_len),
        .o_inc        (f_inc),
        .o_color      (f_color)
    );

    assign w_push_data = {f_ctl, f_major, f_minor, f_len, f_inc, f_color};

    lpg_queue #(
        .WIDTH (DESC_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_data   (w_pop_data)
    );

    assign {b_ctl, b_major, b_minor, b_len, b_inc, b_color} = w_pop_data;

    lpg_back #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (b_valid),
        .o_pop_ready (b_ready),
        .i_ctl       (b_ctl),
        .i_major     (b_major),
        .i_minor     (b_minor),
        .i_len       (b_len),
        .i_inc       (b_inc),
        .i_color     (b_color),
        .o_point     (o_point)
    );

endmodule

// ===== sv/lpg_checker.sv =====
module lpg_checker #(
    parameter int COORD_BITS = 6
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [COORD_BITS-1:0]          i_point_x,
    input logic [COORD_BITS-1:0]          i_point_y,
    input logic [lpg_pkg::COLOR_BITS-1:0] i_point_color,
    input logic                           i_last_point
);

    logic w_out_acc;

    assign w_out_acc = i_out_valid && i_out_ready;

    // A point waiting on the receiver holds still.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_point_x)
            && $stable(i_point_y) && $stable(i_point_color) && $stable(i_last_point))
        else $error("output point changed while stalled");

    // Reset empties the output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Inside a line the next point follows at once with the same colour.
    a_line_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !i_last_point |=> i_out_valid
            && i_point_color == $past(i_point_color))
        else $error("line broken before its last point");

    // Consecutive points of a line are neighbours and never repeat.
    a_neighbour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !i_last_point |=>
            (i_point_x == $past(i_point_x)
                || i_point_x == COORD_BITS'($past(i_point_x) + 1'b1)
                || i_point_x == COORD_BITS'($past(i_point_x) - 1'b1))
            && (i_point_y == $past(i_point_y)
                || i_point_y == COORD_BITS'($past(i_point_y) + 1'b1)
                || i_point_y == COORD_BITS'($past(i_point_y) - 1'b1))
            && (i_point_x != $past(i_point_x) || i_point_y != $past(i_point_y)))
        else $error("points of a line are not adjacent");

endmodule

bind line_point_generator lpg_checker #(
    .COORD_BITS (COORD_BITS)
) u_lpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_point.valid),
    .i_out_ready   (o_point.ready),
    .i_point_x     (o_point.point_x),
    .i_point_y     (o_point.point_y),
    .i_point_color (o_point.point_color),
    .i_last_point  (o_point.last_point)
);

// ===== tb/lpg_point_checker.sv =====
`timescale 1ns / 100ps

module lpg_point_checker #(
    parameter int COORD_BITS    = 6,
    parameter int FRACTION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lpg_in_if    i_line,
    lpg_out_if   i_point,
    output int   o_mismatches,
    output int   o_points_due,
    output int   o_lines_taken,
    output int   o_points_checked
);

    typedef struct packed {
        logic [COORD_BITS-1:0]          x;
        logic [COORD_BITS-1:0]          y;
        logic [lpg_pkg::COLOR_BITS-1:0] color;
        logic                           last;
    } t_point;

    t_point due_points[$];

    // Walks the line exactly as the block should and queues every point.
    function automatic void trace_line(
        input logic [COORD_BITS-1:0]          xs,
        input logic [COORD_BITS-1:0]          ys,
        input logic [COORD_BITS-1:0]          xe,
        input logic [COORD_BITS-1:0]          ye,
        input logic [lpg_pkg::COLOR_BITS-1:0] color
    );
        longint run_d, rise_d, long_d, short_d, unit, slope;
        longint major, acc, stride, count, whole;
        bit     steep;
        t_point p;
        logic [COORD_BITS-1:0] maj_c, mnr_c;
        run_d  = longint'(xe) - longint'(xs);
        rise_d = longint'(ye) - longint'(ys);
        steep  = ((rise_d < 0) ? -rise_d : rise_d) > ((run_d < 0) ? -run_d : run_d);
        long_d  = steep ? rise_d : run_d;
        short_d = steep ? run_d : rise_d;
        unit    = longint'(1) <<< FRACTION_BITS;
        // Signed division truncates toward zero, which is what the slope needs.
        slope  = (long_d == 0) ? 0 : (short_d * unit) / long_d;
        major  = steep ? longint'(ys) : longint'(xs);
        acc    = unit / 2 + (steep ? longint'(xs) : longint'(ys)) * unit;
        stride = (long_d > 0) ? 1 : -1;
        count  = ((long_d < 0) ? -long_d : long_d) + 1;
        for (longint n = 0; n < count; n++) begin
            whole   = acc >>> FRACTION_BITS;
            maj_c   = major[COORD_BITS-1:0];
            mnr_c   = whole[COORD_BITS-1:0];
            p.x     = steep ? mnr_c : maj_c;
            p.y     = steep ? maj_c : mnr_c;
            p.color = color;
            p.last  = (n == count - 1);
            due_points.push_back(p);
            major += stride;
            if (long_d > 0) begin
                acc += slope;
            end else begin
                acc -= slope;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_point got, want;
        if (!i_rst_n) begin
            o_mismatches     = 0;
            o_points_due     = 0;
            o_lines_taken    = 0;
            o_points_checked = 0;
            due_points.delete();
        end else begin
            // Points are checked before the new line is traced, so a point can
            // never be matched against a line taken at the same edge.
            if (i_point.valid && i_point.ready) begin
                got.x     = i_point.point_x;
                got.y     = i_point.point_y;
                got.color = i_point.point_color;
                got.last  = i_point.last_point;
                o_points_checked++;
                if (due_points.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) begin
                        $display("%0t: unexpected point x=%0d y=%0d colour=%06h last=%0b",
                                 $realtime, got.x, got.y, got.color, got.last);
                    end
                end else begin
                    want = due_points.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                        got.color !== want.color || got.last !== want.last) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("%0t: point mismatch, expected x=%0d y=%0d colour=%06h last=%0b",
                                     $realtime, want.x, want.y, want.color, want.last);
                            $display("%0t:                 got      x=%0d y=%0d colour=%06h last=%0b",
                                     $realtime, got.x, got.y, got.color, got.last);
                        end
                    end
                end
            end
            if (i_line.valid && i_line.ready) begin
                trace_line(i_line.x_start, i_line.y_start, i_line.x_end, i_line.y_end,
                           i_line.pixel_color);
                o_lines_taken++;
            end
            o_points_due = due_points.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int CB = 6;
    localparam int FB = 16;
    localparam int RANDOM_LINES = 370;
    localparam int LONG_STALL   = 600;

    logic clk;
    logic rst_n;

    // Set by the stimulus; the receiver raises stall_done once it has served the request.
    bit steady;
    bit stall_req;
    bit stall_done;

    int mismatches, points_due, lines_taken, points_checked;

    lpg_in_if  #(.COORD_BITS(CB)) line_ch ();
    lpg_out_if #(.COORD_BITS(CB)) point_ch ();

    line_point_generator #(
        .COORD_BITS   (CB),
        .FRACTION_BITS(FB)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_line (line_ch),
        .o_point(point_ch)
    );

    lpg_point_checker #(
        .COORD_BITS   (CB),
        .FRACTION_BITS(FB)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_line          (line_ch),
        .i_point         (point_ch),
        .o_mismatches    (mismatches),
        .o_points_due    (points_due),
        .o_lines_taken   (lines_taken),
        .o_points_checked(points_checked)
    );

    initial clk = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    task automatic send_line(input logic [CB-1:0] xs, input logic [CB-1:0] ys,
                             input logic [CB-1:0] xe, input logic [CB-1:0] ye,
                             input logic [lpg_pkg::COLOR_BITS-1:0] color);
        @(negedge clk);
        line_ch.valid       = 1'b1;
        line_ch.x_start     = xs;
        line_ch.y_start     = ys;
        line_ch.x_end       = xe;
        line_ch.y_end       = ye;
        line_ch.pixel_color = color;
        @(posedge clk);
        while (!line_ch.ready) @(posedge clk);
    endtask

    task automatic pause_lines(input int n);
        if (n > 0) begin
            @(negedge clk);
            line_ch.valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic random_line();
        logic [CB-1:0] xs, ys, xe, ye;
        xs = CB'($urandom_range(0, 63));
        ys = CB'($urandom_range(0, 63));
        if ($urandom_range(0, 3) == 0) begin
            // Short line around the start point, zero length included.
            xe = CB'($urandom_range(xs > 3 ? xs - 3 : 0, xs < 60 ? xs + 3 : 63));
            ye = CB'($urandom_range(ys > 3 ? ys - 3 : 0, ys < 60 ? ys + 3 : 63));
        end else begin
            xe = CB'($urandom_range(0, 63));
            ye = CB'($urandom_range(0, 63));
        end
        if (!steady && $urandom_range(0, 1) == 0) begin
            pause_lines(gap_len());
        end
        send_line(xs, ys, xe, ye, lpg_pkg::COLOR_BITS'($urandom));
    endtask

    // Receiver: random ready pattern, one long hold-off on request.
    initial begin
        point_ch.ready = 1'b0;
        stall_done     = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (stall_req && !stall_done) begin
                @(negedge clk);
                point_ch.ready = 1'b0;
                repeat (LONG_STALL - 1) @(negedge clk);
                stall_done = 1'b1;
            end else if (steady) begin
                @(negedge clk);
                point_ch.ready = 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
                @(negedge clk);
                point_ch.ready = 1'b1;
                repeat ($urandom_range(0, 19)) @(negedge clk);
            end else begin
                @(negedge clk);
                point_ch.ready = 1'b0;
                repeat (gap_len() - 1) @(negedge clk);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Timed out with %0d points still awaited.", points_due);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        rst_n               = 1'b0;
        steady              = 1'b0;
        stall_req           = 1'b0;
        line_ch.valid       = 1'b0;
        line_ch.x_start     = '0;
        line_ch.y_start     = '0;
        line_ch.x_end       = '0;
        line_ch.y_end       = '0;
        line_ch.pixel_color = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single points at two corners, full-length rows and columns both ways,
        // diagonals where the magnitudes are equal, and slopes that go negative.
        send_line(0, 0, 0, 0, 24'h000000);
        send_line(63, 63, 63, 63, 24'hFFFFFF);
        send_line(0, 0, 63, 0, 24'hAAAAAA);
        send_line(63, 63, 0, 63, 24'h555555);
        pause_lines(gap_len());
        send_line(0, 0, 0, 63, 24'h0000FF);
        send_line(63, 63, 63, 0, 24'h00FF00);
        send_line(0, 0, 63, 63, 24'hFF0000);
        send_line(63, 0, 0, 63, 24'h123456);
        send_line(0, 63, 63, 0, 24'hFEDCBA);
        pause_lines(gap_len());
        send_line(63, 63, 0, 0, 24'h800001);
        send_line(10, 5, 3, 7, 24'h7FFFFE);
        send_line(5, 60, 7, 2, 24'h0F0F0F);
        send_line(40, 2, 0, 11, 24'hF0F0F0);
        send_line(0, 62, 63, 1, 24'h3C3C3C);
        pause_lines(gap_len());
        send_line(30, 31, 31, 30, 24'hC3C3C3);
        send_line(1, 0, 0, 63, 24'h010203);
        send_line(62, 63, 63, 0, 24'hA5A5A5);
        send_line(20, 20, 22, 21, 24'h5A5A5A);
        send_line(20, 20, 18, 19, 24'h999999);

        repeat (150) random_line();

        // Back-to-back traffic with no idling on either side.
        steady = 1'b1;
        repeat (80) random_line();
        steady = 1'b0;

        // Long receiver hold-off while lines keep arriving, so the input stalls.
        stall_req = 1'b1;
        repeat (60) random_line();
        wait (stall_done == 1'b1);

        repeat (RANDOM_LINES - 290) random_line();
        pause_lines(1);

        wait (points_due == 0);
        repeat (60) @(posedge clk);

        $display("Sent %0d lines and checked %0d points against the prediction.",
                 lines_taken, points_checked);
        $display("Covered corner cases, random idling, back-to-back traffic and a long output stall.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
